@@ hdl/keyed_byte_substitution_cipher_defines.svh @@
// assertion macros for the rtl
`ifndef KEYED_BYTE_SUBSTITUTION_CIPHER_DEFINES_SVH
`define KEYED_BYTE_SUBSTITUTION_CIPHER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define KBSC_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define KBSC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define KBSC_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define KBSC_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

@@ hdl/kbsc_pkg.sv @@
package kbsc_pkg;

  localparam int unsigned MaxKeyBytesDef = 32;
  localparam int unsigned MinKeyBytesDef = 1;

  // action codes on the input tuser
  localparam logic [1:0] ACT_KEY  = 2'd0;
  localparam logic [1:0] ACT_ENC  = 2'd1;
  localparam logic [1:0] ACT_DEC  = 2'd2;
  localparam logic [1:0] ACT_RSVD = 2'd3;

  // status codes on the output tuser
  localparam logic [1:0] STS_DATA_OK = 2'd0;
  localparam logic [1:0] STS_KEY_OK  = 2'd1;
  localparam logic [1:0] STS_BAD_LEN = 2'd2;
  localparam logic [1:0] STS_NO_KEY  = 2'd3;

  typedef enum logic [1:0] {
    CMD_KEY = 2'd0,
    CMD_ENC = 2'd1,
    CMD_DEC = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] data;
    logic       last;
  } cmd_t;

endpackage

@@ hdl/kbsc_front.sv @@
module kbsc_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_valid_i,
  output logic          s_ready_o,
  input  logic [1:0]    s_action_i,
  input  logic [7:0]    s_data_i,
  input  logic          s_last_i,
  output logic          cmd_valid_o,
  output kbsc_pkg::cmd_t cmd_o,
  input  logic          cmd_pop_i
);

  kbsc_pkg::cmd_t q_mem [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       keep;
  logic       push;
  kbsc_pkg::cmd_t cmd_in;

  // classify; unused action code is taken and dropped
  always_comb begin
    keep        = 1'b1;
    cmd_in.kind = kbsc_pkg::CMD_KEY;
    cmd_in.data = s_data_i;
    cmd_in.last = s_last_i;
    unique case (s_action_i)
      kbsc_pkg::ACT_KEY: cmd_in.kind = kbsc_pkg::CMD_KEY;
      kbsc_pkg::ACT_ENC: cmd_in.kind = kbsc_pkg::CMD_ENC;
      kbsc_pkg::ACT_DEC: cmd_in.kind = kbsc_pkg::CMD_DEC;
      default:           keep = 1'b0;
    endcase
  end

  assign s_ready_o   = (cnt_q != 2'd2);
  assign push        = s_valid_i && s_ready_o && keep;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = q_mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = cmd_pop_i ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, cmd_pop_i};
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

@@ hdl/kbsc_back.sv @@
`include "keyed_byte_substitution_cipher_defines.svh"

module kbsc_back #(
  parameter int unsigned MAX_KEY_BYTES = kbsc_pkg::MaxKeyBytesDef,
  parameter int unsigned MIN_KEY_BYTES = kbsc_pkg::MinKeyBytesDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  input  kbsc_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  output logic           m_valid_o,
  input  logic           m_ready_i,
  output logic [7:0]     m_byte_o,
  output logic [1:0]     m_status_o
);

  localparam int unsigned KW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam int unsigned CW = $clog2(MAX_KEY_BYTES + 2);
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_KEY_BYTES);
  localparam logic [CW-1:0] MinCnt = CW'(MIN_KEY_BYTES);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_LOOK  = 9'b000000010,
    S_CLEAR = 9'b000000100,
    S_RDKEY = 9'b000001000,
    S_MUL   = 9'b000010000,
    S_DIV   = 9'b000100000,
    S_SCAN  = 9'b001000000,
    S_TEST  = 9'b010000000,
    S_WRITE = 9'b100000000
  } state_e;

  state_e st_q, st_d;

  logic [7:0] key_mem [MAX_KEY_BYTES];
  logic [7:0] fwd_mem [256];
  logic [7:0] inv_mem [256];
  logic       taken_mem [256];
  logic [7:0] key_rd_q, fwd_rd_q, inv_rd_q;
  logic       taken_rd_q;

  logic [CW-1:0] cnt_q, cnt_d, cnt_inc, len_q, len_d;
  logic          key_ready_q, key_ready_d;
  logic [7:0]    i_q, i_d;
  logic [KW-1:0] idx_q, idx_d;
  logic [8:0]    mult_q, mult_d;
  logic [15:0]   prod_q, prod_d;
  logic [8:0]    rem_q, rem_d;
  logic [3:0]    dstep_q, dstep_d;
  logic [7:0]    v_q, v_d, seen_q, seen_d, pick_q, pick_d;
  kbsc_pkg::cmd_kind_e kind_q, kind_d;

  logic       m_valid_q, m_valid_d;
  logic [7:0] m_byte_q, m_byte_d;
  logic [1:0] m_status_q, m_status_d;

  logic       cmd_pop, out_load, key_we, look_en, tab_we;
  logic       taken_we, taken_wbit;
  logic [7:0] taken_waddr;
  logic [9:0] shifted;
  logic [9:0] divisor;

  assign cmd_pop = cmd_valid_i && (st_q == S_IDLE) && (!m_valid_q || m_ready_i);
  assign cnt_inc = (cnt_q <= MaxCnt) ? cnt_q + CW'(1) : cnt_q;
  assign key_we  = cmd_pop && (cmd_i.kind == kbsc_pkg::CMD_KEY) && (cnt_q < MaxCnt);
  assign look_en = cmd_pop && (cmd_i.kind != kbsc_pkg::CMD_KEY) && key_ready_q;
  assign tab_we  = (st_q == S_WRITE);
  assign divisor = 10'd256 - {2'b00, i_q};
  assign shifted = {rem_q, prod_q[15]};

  // taken flags: cleared by a pass before each build, set as values are picked
  assign taken_we    = (st_q == S_CLEAR) || tab_we;
  assign taken_waddr = (st_q == S_CLEAR) ? i_q : pick_q;
  assign taken_wbit  = (st_q != S_CLEAR);

  always_comb begin
    st_d        = st_q;
    cnt_d       = cnt_q;
    len_d       = len_q;
    key_ready_d = key_ready_q;
    i_d         = i_q;
    idx_d       = idx_q;
    mult_d      = mult_q;
    prod_d      = prod_q;
    rem_d       = rem_q;
    dstep_d     = dstep_q;
    v_d         = v_q;
    seen_d      = seen_q;
    pick_d      = pick_q;
    kind_d      = kind_q;
    out_load    = 1'b0;
    m_byte_d    = m_byte_q;
    m_status_d  = m_status_q;
    m_valid_d   = m_valid_q && !m_ready_i;

    unique case (st_q)
      S_IDLE: begin
        if (cmd_pop) begin
          kind_d = cmd_i.kind;
          if (cmd_i.kind == kbsc_pkg::CMD_KEY) begin
            cnt_d = cnt_inc;
            if (cmd_i.last) begin
              cnt_d = '0;
              if (cnt_inc < MinCnt || cnt_inc > MaxCnt) begin
                out_load   = 1'b1;
                m_byte_d   = 8'd0;
                m_status_d = kbsc_pkg::STS_BAD_LEN;
              end else begin
                len_d  = cnt_inc;
                i_d    = 8'd0;
                idx_d  = '0;
                mult_d = 9'd1;
                st_d   = S_CLEAR;
              end
            end
          end else if (!key_ready_q) begin
            out_load   = 1'b1;
            m_byte_d   = 8'd0;
            m_status_d = kbsc_pkg::STS_NO_KEY;
          end else begin
            st_d = S_LOOK;
          end
        end
      end
      S_LOOK: begin
        out_load   = 1'b1;
        m_byte_d   = (kind_q == kbsc_pkg::CMD_ENC) ? fwd_rd_q : inv_rd_q;
        m_status_d = kbsc_pkg::STS_DATA_OK;
        st_d       = S_IDLE;
      end
      S_CLEAR: begin
        if (i_q == 8'hff) begin
          i_d  = 8'd0;
          st_d = S_RDKEY;
        end else begin
          i_d = i_q + 8'd1;
        end
      end
      S_RDKEY: st_d = S_MUL;
      S_MUL: begin
        prod_d  = 16'(key_rd_q * mult_q);
        rem_d   = 9'd0;
        dstep_d = 4'd0;
        st_d    = S_DIV;
      end
      S_DIV: begin
        // restoring remainder, one dividend bit a cycle
        rem_d   = (shifted >= divisor) ? 9'(shifted - divisor) : shifted[8:0];
        prod_d  = {prod_q[14:0], 1'b0};
        dstep_d = dstep_q + 4'd1;
        if (dstep_q == 4'd15) begin
          v_d    = 8'd0;
          seen_d = 8'd0;
          st_d   = S_SCAN;
        end
      end
      // flag of v is read here and tested in the next cycle
      S_SCAN: st_d = S_TEST;
      S_TEST: begin
        // walk values upward, counting the free ones until the rank is hit
        v_d  = v_q + 8'd1;
        st_d = S_SCAN;
        if (!taken_rd_q) begin
          if (seen_q == rem_q[7:0]) begin
            pick_d = v_q;
            st_d   = S_WRITE;
          end else begin
            seen_d = seen_q + 8'd1;
          end
        end
      end
      S_WRITE: begin
        if (i_q == 8'hff) begin
          key_ready_d = 1'b1;
          out_load    = 1'b1;
          m_byte_d    = 8'd0;
          m_status_d  = kbsc_pkg::STS_KEY_OK;
          st_d        = S_IDLE;
        end else begin
          i_d = i_q + 8'd1;
          if (CW'(idx_q) == len_q - CW'(1)) begin
            idx_d  = '0;
            mult_d = mult_q + 9'd1;
          end else begin
            idx_d = idx_q + KW'(1);
          end
          st_d = S_RDKEY;
        end
      end
      default: st_d = S_IDLE;
    endcase

    if (out_load) begin
      m_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[cnt_q[KW-1:0]] <= cmd_i.data;
    end
    if (st_q == S_RDKEY) begin
      key_rd_q <= key_mem[idx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (taken_we) begin
      taken_mem[taken_waddr] <= taken_wbit;
    end
    if (st_q == S_SCAN) begin
      taken_rd_q <= taken_mem[v_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (tab_we) begin
      fwd_mem[i_q] <= pick_q;
    end
    if (look_en) begin
      fwd_rd_q <= fwd_mem[cmd_i.data];
    end
  end

  always_ff @(posedge clk_i) begin
    if (tab_we) begin
      inv_mem[pick_q] <= i_q;
    end
    if (look_en) begin
      inv_rd_q <= inv_mem[cmd_i.data];
    end
  end

  always_ff @(posedge clk_i) begin
    len_q      <= len_d;
    i_q        <= i_d;
    idx_q      <= idx_d;
    mult_q     <= mult_d;
    prod_q     <= prod_d;
    rem_q      <= rem_d;
    dstep_q    <= dstep_d;
    v_q        <= v_d;
    seen_q     <= seen_d;
    pick_q     <= pick_d;
    kind_q     <= kind_d;
    m_byte_q   <= m_byte_d;
    m_status_q <= m_status_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      cnt_q       <= '0;
      key_ready_q <= 1'b0;
      m_valid_q   <= 1'b0;
    end else begin
      st_q        <= st_d;
      cnt_q       <= cnt_d;
      key_ready_q <= key_ready_d;
      m_valid_q   <= m_valid_d;
    end
  end

  assign cmd_pop_o  = cmd_pop;
  assign m_valid_o  = m_valid_q;
  assign m_byte_o   = m_byte_q;
  assign m_status_o = m_status_q;

  `KBSC_ASSERT_IMPL(a_pop_only_idle, clk_i, rst_ni, cmd_pop, st_q == S_IDLE)
  `KBSC_ASSERT_IMPL(a_no_overwrite, clk_i, rst_ni, out_load, !m_valid_q || m_ready_i)
  `KBSC_ASSERT_IMPL(a_seen_below_rank, clk_i, rst_ni, st_q == S_TEST, seen_q <= rem_q[7:0])
  `KBSC_ASSERT_NEXT(a_clear_to_key, clk_i, rst_ni, (st_q == S_CLEAR) && (i_q == 8'hff), st_q == S_RDKEY)
  `KBSC_ASSERT_NEXT(a_build_sets_ready, clk_i, rst_ni, tab_we && (i_q == 8'hff), key_ready_q)

endmodule

@@ hdl/keyed_byte_substitution_cipher.sv @@
// lookup item: result through queue slot, table read and result register; the back end takes
//   no new item until that result is in the result register; key byte not marked last: no result
// last key byte: a bad length answers from idle straight into the result register; a good key first
//   clears the taken flags, then builds 256 entries, each a key byte read, multiply, divide and a scan
//   of the values (up to 256) until the free value of the rank is found, then a table write
// reset (async, active low) clears the key count, ready flag and all handshakes
module keyed_byte_substitution_cipher #(
  parameter int unsigned MAX_KEY_BYTES = kbsc_pkg::MaxKeyBytesDef,
  parameter int unsigned MIN_KEY_BYTES = kbsc_pkg::MinKeyBytesDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input stream
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic [1:0] s_axis_tuser,   // [1:0] action
  input  logic       s_axis_tlast,   // last key byte
  // result stream
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic [1:0] m_axis_tuser    // [1:0] status
);

  logic           cmd_valid;
  logic           cmd_pop;
  kbsc_pkg::cmd_t cmd;

  // front end: decodes the action and queues the item
  // a 2-entry command queue keeps taking items, until it is full, while the table build or output stalls
  kbsc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .s_action_i  (s_axis_tuser),
    .s_data_i    (s_axis_tdata),
    .s_last_i    (s_axis_tlast),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  // back end: key collection, table build, lookups and result register
  kbsc_back #(
    .MAX_KEY_BYTES (MAX_KEY_BYTES),
    .MIN_KEY_BYTES (MIN_KEY_BYTES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_byte_o    (m_axis_tdata),
    .m_status_o  (m_axis_tuser)
  );

endmodule
